// File: hw/rtl/tsc_pkg.sv
// Shared types, widths and helper functions for the Taylor sine/cosine pipeline.
package tsc_pkg;

   localparam int DEF_HIGHEST_POWER = 30;

   localparam int ANGLE_W = 31;
   localparam int VALUE_W = 32;
   localparam int FRAC_BITS = 36;
   localparam int TERM_W = 45;
   localparam int ACC_W = 50;

   localparam logic ACTION_SINE = 1'b0;
   localparam logic ACTION_COSINE = 1'b1;

   // Sign pattern of a series term, chosen by the power modulo four.
   localparam logic [1:0] PHASE_EVEN_PLUS = 2'd0;
   localparam logic [1:0] PHASE_ODD_PLUS = 2'd1;
   localparam logic [1:0] PHASE_EVEN_MINUS = 2'd2;
   localparam logic [1:0] PHASE_ODD_MINUS = 2'd3;

   localparam logic [TERM_W-1:0] ONE_TERM = TERM_W'(64'd1 << FRAC_BITS);
   localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(64'd1 << FRAC_BITS);
   localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(64'd32);
   localparam logic signed [VALUE_W-1:0] VALUE_ONE = 32'sd1073741824;

   typedef struct packed {
      logic action;
      logic [ANGLE_W-1:0] angle;
      logic signed [ACC_W-1:0] acc;
   } ctx_type;

   typedef struct packed {
      ctx_type ctx;
      logic [TERM_W-1:0] term;
   } lane_type;

   // Signed contribution of the term of the given power to the running sum.
   function automatic logic signed [ACC_W-1:0] term_contrib(
      input logic [4:0] power,
      input logic action,
      input logic [TERM_W-1:0] term
   );
      logic signed [ACC_W-1:0] mag;
      logic signed [ACC_W-1:0] result;
      mag = $signed({{(ACC_W-TERM_W){1'b0}}, term});
      result = '0;
      if (power[0] != action) begin
         case (power[1:0])
            PHASE_EVEN_PLUS: result = mag;
            PHASE_ODD_PLUS: result = mag;
            PHASE_EVEN_MINUS: result = -mag;
            PHASE_ODD_MINUS: result = -mag;
            default: result = '0;
         endcase
      end
      return result;
   endfunction

endpackage

// File: hw/rtl/taylor_sine_cosine_core.sv
// Top level of the pipelined Taylor series sine and cosine core.
//
// Each item carries an unsigned Q3.28 angle in radians and a selector (0 sine,
// 1 cosine); the core returns the truncated Taylor series with powers up to
// HIGHEST_POWER as a signed Q2.30 value saturated to plus or minus one. No
// angle reduction is done, so angles far beyond a quarter turn give the raw
// series value. The core is fully pipelined and takes one item every clock
// cycle while no presented result is stalled. Each term of power one and up
// has its own five-stage unit: the previous term times the angle as two
// partial products, a rounding add, and an exact division by the power done
// as three 16-bit digits by a reciprocal multiply. Two more stages add the
// last term, clamp and round into the output register. The whole pipeline
// holds while a result is presented and rsp_stall is high; at that time
// req_stall is high as well.
module taylor_sine_cosine_core #(
   parameter int HIGHEST_POWER = tsc_pkg::DEF_HIGHEST_POWER
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_action,
   input logic [tsc_pkg::ANGLE_W-1:0] req_angle,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic signed [tsc_pkg::VALUE_W-1:0] rsp_value
);
   import tsc_pkg::*;

   // The pipeline moves as one unless the presented result is held back.
   logic advance;

   // Valid bits and lanes between the term units; entry zero is the new item.
   logic [HIGHEST_POWER:0] chain_valid;
   lane_type chain_lane [0:HIGHEST_POWER];

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // A new item starts with the zeroth-power term equal to one and an empty sum.
   assign chain_valid[0] = req_valid;
   assign chain_lane[0] = {req_action, req_angle, {ACC_W{1'b0}}, ONE_TERM};

   for (genvar k = 1; k <= HIGHEST_POWER; k++) begin : g_term
      tsc_term #(
         .POWER(k)
      ) u_term (
         .clock(clock),
         .reset(reset),
         .advance(advance),
         .in_valid(chain_valid[k-1]),
         .in_lane(chain_lane[k-1]),
         .out_valid(chain_valid[k]),
         .out_lane(chain_lane[k])
      );
   end

   // The last term is added here; the output register sits in this unit.
   tsc_finish #(
      .POWER(HIGHEST_POWER)
   ) u_finish (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .in_valid(chain_valid[HIGHEST_POWER]),
      .in_lane(chain_lane[HIGHEST_POWER]),
      .out_valid(rsp_valid),
      .out_value(rsp_value)
   );

   // After a reset cycle no result is presented.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result presented right after reset");

   // Saturation keeps every presented result within plus or minus one.
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value <= VALUE_ONE && rsp_value >= -VALUE_ONE))
      else $error("result outside plus or minus one");

   // A result can only newly appear on an edge at which the pipeline moved.
   a_rise_on_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_stall))
      else $error("result appeared while the pipeline was held");

endmodule

// File: hw/rtl/tsc_term.sv
// One series term: angle multiply, rounding add and three-digit division by the power.
module tsc_term #(
   parameter int POWER = 1
) (
   input logic clock,
   input logic reset,
   input logic advance,
   input logic in_valid,
   input tsc_pkg::lane_type in_lane,
   output logic out_valid,
   output tsc_pkg::lane_type out_lane
);
   import tsc_pkg::*;

   localparam logic [75:0] HALF_ADD = 76'(POWER / 2) << 28;
   localparam logic [26:0] RECIP = 27'(((64'd1 << 26) + 64'(POWER) - 64'd1) / 64'(POWER));
   localparam logic [20:0] DIVISOR = 21'(POWER);

   // Exact floor(v / POWER) for v below 2^21 by a rounded-up reciprocal.
   function automatic logic [20:0] digit_quo(input logic [20:0] v);
      logic [47:0] prod;
      prod = 48'(v) * 48'(RECIP);
      return prod[46:26];
   endfunction

   // Stage 1: partial products of the previous term and the angle.
   logic s1_valid_ff;
   ctx_type s1_ctx_ff, s1_ctx_in;
   logic [43:0] s1_hi_ff, s1_hi_in;
   logic [62:0] s1_lo_ff, s1_lo_in;

   // Stage 2: product scaled to Q.36 with half the divisor added.
   logic s2_valid_ff;
   ctx_type s2_ctx_ff;
   logic [47:0] s2_num_ff, s2_num_in;
   logic [75:0] s2_sum;

   // Stages 3 to 5: one 16-bit digit of the quotient each.
   logic s3_valid_ff;
   ctx_type s3_ctx_ff;
   logic [15:0] s3_quo_ff, s3_quo_in;
   logic [4:0] s3_rem_ff, s3_rem_in;
   logic [31:0] s3_low_ff;
   logic [20:0] s3_part, s3_q;

   logic s4_valid_ff;
   ctx_type s4_ctx_ff;
   logic [31:0] s4_quo_ff, s4_quo_in;
   logic [4:0] s4_rem_ff, s4_rem_in;
   logic [15:0] s4_low_ff;
   logic [20:0] s4_part, s4_q;

   logic s5_valid_ff;
   lane_type s5_lane_ff, s5_lane_in;
   logic [20:0] s5_part, s5_q;
   logic [47:0] s5_quo;

   always_comb begin
      s1_ctx_in = in_lane.ctx;
      s1_ctx_in.acc = in_lane.ctx.acc
         + term_contrib(5'(POWER - 1), in_lane.ctx.action, in_lane.term);
      s1_hi_in = 44'(in_lane.term[TERM_W-1:32]) * 44'(in_lane.ctx.angle);
      s1_lo_in = 63'(in_lane.term[31:0]) * 63'(in_lane.ctx.angle);
   end

   always_comb begin
      s2_sum = {s1_hi_ff, 32'd0} + 76'(s1_lo_ff) + HALF_ADD;
      s2_num_in = s2_sum[75:28];
   end

   always_comb begin
      s3_part = {5'd0, s2_num_ff[47:32]};
      s3_q = digit_quo(s3_part);
      s3_quo_in = s3_q[15:0];
      s3_rem_in = 5'(s3_part - s3_q * DIVISOR);
   end

   always_comb begin
      s4_part = {s3_rem_ff, s3_low_ff[31:16]};
      s4_q = digit_quo(s4_part);
      s4_quo_in = {s3_quo_ff, s4_q[15:0]};
      s4_rem_in = 5'(s4_part - s4_q * DIVISOR);
   end

   always_comb begin
      s5_part = {s4_rem_ff, s4_low_ff};
      s5_q = digit_quo(s5_part);
      s5_quo = {s4_quo_ff, s5_q[15:0]};
      s5_lane_in.ctx = s4_ctx_ff;
      s5_lane_in.term = s5_quo[TERM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ctx_ff <= s1_ctx_in;
         s1_hi_ff <= s1_hi_in;
         s1_lo_ff <= s1_lo_in;
         s2_ctx_ff <= s1_ctx_ff;
         s2_num_ff <= s2_num_in;
         s3_ctx_ff <= s2_ctx_ff;
         s3_quo_ff <= s3_quo_in;
         s3_rem_ff <= s3_rem_in;
         s3_low_ff <= s2_num_ff[31:0];
         s4_ctx_ff <= s3_ctx_ff;
         s4_quo_ff <= s4_quo_in;
         s4_rem_ff <= s4_rem_in;
         s4_low_ff <= s3_low_ff[15:0];
         s5_lane_ff <= s5_lane_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_lane = s5_lane_ff;

endmodule

// File: hw/rtl/tsc_finish.sv
// Last term of the sum, clamping to plus or minus one and rounding to Q2.30.
module tsc_finish #(
   parameter int POWER = 30
) (
   input logic clock,
   input logic reset,
   input logic advance,
   input logic in_valid,
   input tsc_pkg::lane_type in_lane,
   output logic out_valid,
   output logic signed [tsc_pkg::VALUE_W-1:0] out_value
);
   import tsc_pkg::*;

   logic sum_valid_ff;
   logic signed [ACC_W-1:0] sum_ff, sum_in;

   logic value_valid_ff;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic signed [ACC_W-1:0] clamped, biased, shifted;

   assign sum_in = in_lane.ctx.acc
      + term_contrib(5'(POWER), in_lane.ctx.action, in_lane.term);

   always_comb begin
      if (sum_ff > ACC_ONE) begin
         clamped = ACC_ONE;
      end else if (sum_ff < -ACC_ONE) begin
         clamped = -ACC_ONE;
      end else begin
         clamped = sum_ff;
      end
      biased = clamped + ACC_ROUND;
      shifted = biased >>> 6;
      value_in = shifted[VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         value_valid_ff <= 1'b0;
      end else if (advance) begin
         sum_valid_ff <= in_valid;
         value_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
         value_ff <= value_in;
      end
   end

   assign out_valid = value_valid_ff;
   assign out_value = value_ff;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the pipelined Taylor series sine and cosine core.
`timescale 1ns / 100ps

module tb;
   import tsc_pkg::*;

   // The core runs at its default series length; the predictor follows it.
   localparam int HIGHEST_POWER = DEF_HIGHEST_POWER;

   // Each term unit is five stages deep and two more stages finish the sum,
   // so this constant is the number of stages from acceptance to presentation.
   localparam int PIPE_LATENCY = 5 * HIGHEST_POWER + 2;

   // Last angle of the intended range, just above two pi in Q3.28.
   localparam logic [ANGLE_W-1:0] ANGLE_TOP = 31'd1694901469;
   localparam logic [ANGLE_W-1:0] QUARTER_TURN = 31'd421657428;
   localparam logic [ANGLE_W-1:0] HALF_TURN = 31'd843314857;
   localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 31'd1264972285;
   localparam logic [ANGLE_W-1:0] FULL_TURN = 31'd1686629713;

   localparam int RANDOM_ITEMS = 1600;
   localparam int PHASE_ITEMS = 100;
   localparam int MAX_REPORTS = 100;

   // Holds the expected series values in acceptance order and compares the
   // presented results against them.
   class series_ledger #(int POWERS = 30);
      logic signed [VALUE_W-1:0] pending_values[$];
      int failures;

      function new();
         failures = 0;
      endfunction

      // Truncated series with each term derived from the previous one:
      // t(i) = round(t(i-1) * angle / i), all magnitudes in Q.36.
      static function logic signed [VALUE_W-1:0] taylor_value(
         input logic action,
         input logic [ANGLE_W-1:0] angle
      );
         logic [79:0] wide_term;
         logic [79:0] wide_angle;
         logic [79:0] product;
         logic [63:0] scaled;
         logic [63:0] term;
         longint sum;
         longint unity;
         longint rounded;
         unity = longint'(64'd1 << FRAC_BITS);
         term = 64'd1 << FRAC_BITS;
         sum = (action == ACTION_COSINE) ? unity : 64'sd0;
         wide_angle = {49'd0, angle};
         for (int i = 1; i <= POWERS; i++) begin
            wide_term = {16'd0, term};
            product = wide_term * wide_angle;
            scaled = 64'(product >> 28);
            term = (scaled + 64'(i / 2)) / 64'(i);
            // Sine keeps the odd powers, cosine the even ones; the sign
            // follows the power modulo four.
            if (((i % 2) == 1) != (action == ACTION_COSINE)) begin
               if ((i % 4) == 1 || (i % 4) == 0)
                  sum = sum + longint'(term);
               else
                  sum = sum - longint'(term);
            end
         end
         if (sum > unity)
            sum = unity;
         if (sum < -unity)
            sum = -unity;
         // Round to Q.30 with halves going up, working on a nonnegative offset.
         rounded = (sum + unity + 64'sd32) >>> 6;
         return VALUE_W'(rounded - 64'sd1073741824);
      endfunction

      function void note_request(input logic action, input logic [ANGLE_W-1:0] angle);
         pending_values.push_back(taylor_value(action, angle));
      endfunction

      function void check_value(input logic signed [VALUE_W-1:0] actual);
         logic signed [VALUE_W-1:0] wanted;
         if (pending_values.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $error("value: no item pending, actual %0d", actual);
         end else begin
            wanted = pending_values.pop_front();
            if (actual !== wanted) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $error("value: expected %0d, actual %0d", wanted, actual);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = ACTION_SINE;
   logic [ANGLE_W-1:0] req_angle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_value;

   // Chances out of a hundred that the sender idles or the receiver stalls
   // in a given cycle; the stimulus loop changes them phase by phase.
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   // Phases in turn: no idling, a lazy sender, a lazy receiver, and both a
   // little lazy. Cycling through them puts gaps at every point of the work.
   int idle_by_phase[4] = '{0, 59, 0, 13};
   int stall_by_phase[4] = '{0, 0, 59, 13};

   series_ledger #(HIGHEST_POWER) ledger;

   taylor_sine_cosine_core #(
      .HIGHEST_POWER(HIGHEST_POWER)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_angle(req_angle),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Receiver: checks every accepted result against the oldest expectation
   // and picks next cycle's stall. The check reads the stall that was in
   // force at this edge, before the new value lands.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            ledger.check_value(rsp_value);
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Offers one item, possibly after a few idle cycles, and holds it steady
   // until the core takes it. The expectation is recorded at acceptance.
   task automatic send_item(input logic action, input logic [ANGLE_W-1:0] angle);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_angle <= angle;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      ledger.note_request(action, angle);
   endtask

   // Sends the same angle as a sine and as a cosine.
   task automatic send_both(input logic [ANGLE_W-1:0] angle);
      send_item(ACTION_SINE, angle);
      send_item(ACTION_COSINE, angle);
   endtask

   // Most angles lie in the intended range; the rest cover every bit of the
   // field, tiny angles where few terms matter, and the neighborhoods of the
   // quarter turns where the sum sits near plus or minus one.
   function automatic logic [ANGLE_W-1:0] pick_angle();
      int unsigned roll;
      logic [ANGLE_W-1:0] base;
      roll = $urandom_range(99);
      if (roll < 65)
         return ANGLE_W'($urandom_range(ANGLE_TOP, 0));
      if (roll < 80)
         return ANGLE_W'($urandom);
      if (roll < 90)
         return ANGLE_W'($urandom_range(1 << 20, 0));
      case ($urandom_range(3))
         0: base = QUARTER_TURN;
         1: base = HALF_TURN;
         2: base = THREE_QUARTER_TURN;
         default: base = FULL_TURN;
      endcase
      return base + ANGLE_W'($urandom_range(4096)) - ANGLE_W'(2048);
   endfunction

   initial begin
      ledger = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items: zero, the smallest step, the quarter turns, the top
      // of the intended range, the largest value of the field, a single high
      // bit and two alternating bit patterns.
      send_both('0);
      send_both(31'd1);
      send_both(QUARTER_TURN);
      send_both(HALF_TURN);
      send_both(THREE_QUARTER_TURN);
      send_both(FULL_TURN);
      send_both(ANGLE_TOP);
      send_both(31'h4000_0000);
      send_both(31'h7FFF_FFFF);
      send_both(31'h2AAA_AAAA);
      send_both(31'h5555_5555);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sender_idle_pct = idle_by_phase[(n / PHASE_ITEMS) % 4];
         receiver_stall_pct = stall_by_phase[(n / PHASE_ITEMS) % 4];
         send_item(logic'($urandom_range(1)), pick_angle());
      end
      req_valid <= 1'b0;

      // Drain: let every expected result arrive, then watch a full pipeline
      // length for anything extra.
      receiver_stall_pct = 0;
      while (ledger.pending_values.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 8) @(posedge clock);

      if (ledger.failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog: a correct run ends well before this limit even with the
   // slowest phases, so this only fires on a hang.
   initial begin
      #400000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
